// ===== hw/rtl/bpn_pkg.sv =====
// bpn_pkg: shared types and codes for the benes permutation network
// no dependencies; imported by every module of the block
package bpn_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRACE,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  localparam int unsigned SWITCH_BITS = 64;
  localparam int unsigned OUT_WIDTH   = 32;
  localparam int unsigned PORT_WIDTH  = 7;

endpackage

// ===== hw/rtl/bpn_switch_mem.sv =====
// bpn_switch_mem: switch setting memory, one 64-bit word per stage
// uses bpn_pkg; per-stage valid bits make unloaded stages read as straight
module bpn_switch_mem import bpn_pkg::*; #(
  parameter int NUM_STAGES = 13
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mem_ctl_t                              ctl,
  input  logic [$clog2(NUM_STAGES)-1:0]         wr_addr,
  input  logic [SWITCH_BITS-1:0]                wr_data,
  input  logic [$clog2(NUM_STAGES)-1:0]         rd_addr,
  output logic [SWITCH_BITS-1:0]                rd_data
);

  logic [SWITCH_BITS-1:0] mem [NUM_STAGES];
  logic [NUM_STAGES-1:0]  valid_r;
  logic [SWITCH_BITS-1:0] rdata_r;
  logic                   rvalid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rvalid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule

// ===== hw/rtl/bpn_data_mem.sv =====
// bpn_data_mem: element store, one entry per input port
// uses bpn_pkg; contents are undefined until written
module bpn_data_mem import bpn_pkg::*; #(
  parameter int LOG_PORTS  = 7,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  mem_ctl_t              ctl,
  input  logic [LOG_PORTS-1:0]  wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [LOG_PORTS-1:0]  rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [2**LOG_PORTS];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign rd_data = rdata_r;

endmodule

// ===== hw/rtl/bpn_tracer.sv =====
// bpn_tracer: request decode and back-trace sequencer, one stage per cycle
// uses bpn_pkg; drives bpn_switch_mem and bpn_data_mem, holds the result register
module bpn_tracer import bpn_pkg::*; #(
  parameter int LOG_PORTS     = 7,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              in_opcode,
  input  logic [3:0]                              in_stage,
  input  logic [SWITCH_BITS-1:0]                  in_switch_word,
  input  logic [PORT_WIDTH-1:0]                   in_port,
  input  logic [OUT_WIDTH-1:0]                    in_element,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [OUT_WIDTH-1:0]                    out_value,
  output logic [PORT_WIDTH-1:0]                   out_port,
  output mem_ctl_t                                sw_ctl,
  output logic [$clog2(2*LOG_PORTS-1)-1:0]        sw_wr_addr,
  output logic [SWITCH_BITS-1:0]                  sw_wr_data,
  output logic [$clog2(2*LOG_PORTS-1)-1:0]        sw_rd_addr,
  input  logic [SWITCH_BITS-1:0]                  sw_rd_data,
  output mem_ctl_t                                dm_ctl,
  output logic [LOG_PORTS-1:0]                    dm_wr_addr,
  output logic [((ELEMENT_WIDTH < 32) ? ELEMENT_WIDTH : 32)-1:0] dm_wr_data,
  output logic [LOG_PORTS-1:0]                    dm_rd_addr,
  input  logic [((ELEMENT_WIDTH < 32) ? ELEMENT_WIDTH : 32)-1:0] dm_rd_data
);

  localparam int PW  = LOG_PORTS;
  localparam int NS  = 2 * LOG_PORTS - 1;
  localparam int SAW = $clog2(NS);
  localparam int DW  = (ELEMENT_WIDTH < 32) ? ELEMENT_WIDTH : 32;
  localparam logic [SAW-1:0] LAST_STAGE = SAW'(NS - 1);

  state_t                state_r, state_nxt;
  logic [SAW-1:0]        cnt_r, cnt_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [PORT_WIDTH-1:0] port_r, port_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_WIDTH-1:0]  out_value_r, out_value_nxt;
  logic [PORT_WIDTH-1:0] out_port_r, out_port_nxt;

  opcode_t       op;
  logic          stage_ok;
  logic [PW-1:0] port_m;
  logic [5:0]    bidx;
  logic [PW-1:0] sw_pos;
  logic [PW-1:0] pos_step;
  logic          out_load;

  // position before the inter-stage wiring of level lvl, given position after it
  function automatic logic [PW-1:0] wire_back(input logic [PW-1:0] p,
                                              input logic [SAW-1:0] lvl);
    int            lg;
    logic          unshuf;
    logic [PW-1:0] r;
    if (int'(lvl) < PW - 1) begin
      lg     = PW - int'(lvl);
      unshuf = 1'b1;
    end else if (int'(lvl) == PW - 1) begin
      lg     = 2;
      unshuf = 1'b1;
    end else begin
      lg     = int'(lvl) - PW + 3;
      unshuf = 1'b0;
    end
    for (int i = 0; i < PW; i++) begin
      if (i >= lg) begin
        r[i] = p[i];
      end else if (unshuf) begin
        r[i] = (i == 0) ? p[lg-1] : p[(i + PW - 1) % PW];
      end else begin
        r[i] = (i == lg - 1) ? p[0] : p[(i + 1) % PW];
      end
    end
    return r;
  endfunction

  assign op       = opcode_t'(in_opcode);
  assign stage_ok = 5'(in_stage) < 5'(NS);
  assign port_m   = PW'(in_port);

  assign bidx     = 6'(pos_r >> 1);
  assign sw_pos   = pos_r ^ PW'(sw_rd_data[bidx]);
  assign pos_step = (cnt_r != '0) ? wire_back(sw_pos, cnt_r - 1'b1) : sw_pos;

  assign sw_wr_addr = SAW'(in_stage);
  assign sw_wr_data = in_switch_word;
  assign dm_wr_addr = port_m;
  assign dm_wr_data = in_element[DW-1:0];
  assign dm_rd_addr = pos_step;

  // output decode
  always_comb begin
    in_ready   = 1'b0;
    sw_ctl     = '0;
    dm_ctl     = '0;
    sw_rd_addr = LAST_STAGE;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (op)
            OP_LOAD:  sw_ctl.wr_en = stage_ok;
            OP_WRITE: dm_ctl.wr_en = 1'b1;
            OP_READ:  sw_ctl.rd_en = 1'b1;
            default: ;
          endcase
        end
      end
      ST_TRACE: begin
        if (cnt_r != '0) begin
          sw_ctl.rd_en = 1'b1;
          sw_rd_addr   = cnt_r - 1'b1;
        end else begin
          dm_ctl.rd_en = 1'b1;
        end
      end
      ST_FETCH: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && op == OP_READ) state_nxt = ST_TRACE;
      ST_TRACE: if (cnt_r == '0) state_nxt = ST_FETCH;
      ST_FETCH: if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    port_nxt      = port_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_port_nxt  = out_port_r;
    if (state_r == ST_IDLE && in_valid && op == OP_READ) begin
      cnt_nxt  = LAST_STAGE;
      pos_nxt  = port_m;
      port_nxt = PORT_WIDTH'(port_m);
    end else if (state_r == ST_TRACE) begin
      cnt_nxt = cnt_r - 1'b1;
      pos_nxt = pos_step;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = OUT_WIDTH'(dm_rd_data);
      out_port_nxt  = port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    pos_r       <= pos_nxt;
    port_r      <= port_nxt;
    out_value_r <= out_value_nxt;
    out_port_r  <= out_port_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_port  = out_port_r;

`ifndef SYNTHESIS
  a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_READ) |=>
      (state_r == ST_TRACE && cnt_r == LAST_STAGE))
    else $error("read request did not start a trace at the last stage");

  a_trace_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRACE && cnt_r == '0) |=> (state_r == ST_FETCH))
    else $error("trace did not move to element fetch after stage zero");

  a_fetch_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH && (!out_valid_r || out_ready)) |=>
      (out_valid_r && state_r == ST_IDLE && out_port_r == $past(port_r)))
    else $error("element fetch did not load the result register");

  a_no_mem_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(sw_ctl.wr_en && sw_ctl.rd_en) && !(dm_ctl.wr_en && dm_ctl.rd_en))
    else $error("memory read and write issued in the same cycle");
`endif

endmodule

// ===== hw/rtl/benes_permutation_network.sv =====
// benes_permutation_network: top level, 2^LOG_PORTS-port benes network
// uses bpn_pkg, bpn_switch_mem, bpn_data_mem and bpn_tracer
//
// A load of one stage's switch word or a write of one input element is taken,
// and the next request is accepted in the cycle after. No request is accepted
// while a read of an output port is in progress: the sequencer traces the port
// back one stage per cycle through the switch memory (2*LOG_PORTS-1 stages),
// then reads the element memory once, and, once the output register is free,
// places the element and the port in that register, which holds them until
// taken.
// Switch stages read as straight until loaded; elements read from input ports
// never written are undefined.
module benes_permutation_network import bpn_pkg::*; #(
  parameter int LOG_PORTS     = 7,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_opcode,
  input  logic [3:0]             in_stage,
  input  logic [SWITCH_BITS-1:0] in_switch_word,
  input  logic [PORT_WIDTH-1:0]  in_port,
  input  logic [OUT_WIDTH-1:0]   in_element,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_WIDTH-1:0]   out_value,
  output logic [PORT_WIDTH-1:0]  out_port
);

  localparam int NS  = 2 * LOG_PORTS - 1;
  localparam int SAW = $clog2(NS);
  localparam int DW  = (ELEMENT_WIDTH < 32) ? ELEMENT_WIDTH : 32;

  mem_ctl_t               sw_ctl;
  logic [SAW-1:0]         sw_wr_addr;
  logic [SWITCH_BITS-1:0] sw_wr_data;
  logic [SAW-1:0]         sw_rd_addr;
  logic [SWITCH_BITS-1:0] sw_rd_data;
  mem_ctl_t               dm_ctl;
  logic [LOG_PORTS-1:0]   dm_wr_addr;
  logic [DW-1:0]          dm_wr_data;
  logic [LOG_PORTS-1:0]   dm_rd_addr;
  logic [DW-1:0]          dm_rd_data;

  bpn_tracer #(
    .LOG_PORTS     (LOG_PORTS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_tracer (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_stage       (in_stage),
    .in_switch_word (in_switch_word),
    .in_port        (in_port),
    .in_element     (in_element),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_port       (out_port),
    .sw_ctl         (sw_ctl),
    .sw_wr_addr     (sw_wr_addr),
    .sw_wr_data     (sw_wr_data),
    .sw_rd_addr     (sw_rd_addr),
    .sw_rd_data     (sw_rd_data),
    .dm_ctl         (dm_ctl),
    .dm_wr_addr     (dm_wr_addr),
    .dm_wr_data     (dm_wr_data),
    .dm_rd_addr     (dm_rd_addr),
    .dm_rd_data     (dm_rd_data)
  );

  bpn_switch_mem #(
    .NUM_STAGES (NS)
  ) u_switch_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sw_ctl),
    .wr_addr (sw_wr_addr),
    .wr_data (sw_wr_data),
    .rd_addr (sw_rd_addr),
    .rd_data (sw_rd_data)
  );

  bpn_data_mem #(
    .LOG_PORTS  (LOG_PORTS),
    .DATA_WIDTH (DW)
  ) u_data_mem (
    .clk     (clk),
    .ctl     (dm_ctl),
    .wr_addr (dm_wr_addr),
    .wr_data (dm_wr_data),
    .rd_addr (dm_rd_addr),
    .rd_data (dm_rd_data)
  );

endmodule
